/* hw/rtl/prlm_pkg.sv */
package prlm_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned MAX_BLOCK_DEF    = 4096;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned LEVEL_W    = 24;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ACTIVE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  // bits of a squared magnitude, and of the mean of squares
  localparam int unsigned SQ_W = 2 * SAMPLE_W - 1;

  localparam logic [LEVEL_W-1:0]  THRESH_RESET = 24'h800000;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_READ       = 2'd1,
    KIND_READ_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_THRESHOLD  = 8'd0,
    REG_ACTIVE_CHANNELS = 8'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MERGE,
    ST_ROOT
  } state_e;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT,
    RT_DONE
  } root_phase_e;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_block;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] peak_level;
    logic [LEVEL_W-1:0] rms_level;
    logic               clipped;
  } out_item_t;

endpackage

/* hw/rtl/prlm_ram.sv */
module prlm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/prlm_mean_root.sv */
module prlm_mean_root #(
  parameter int unsigned SUM_W = 59,
  parameter int unsigned CNT_W = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SUM_W-1:0]              sum_i,
  input  logic [CNT_W-1:0]              cnt_i,
  output logic                          done_o,
  output logic [prlm_pkg::SAMPLE_W-1:0] root_o
);

  localparam int unsigned QW    = prlm_pkg::SQ_W;
  localparam int unsigned RW    = prlm_pkg::SAMPLE_W;
  localparam int unsigned StepW = $clog2(QW);

  prlm_pkg::root_phase_e phase_q, phase_d;
  logic [StepW-1:0]      step_q;

  logic [CNT_W-1:0]  den_q;
  logic [CNT_W-1:0]  rem_q;
  logic [QW-1:0]     dvd_q;
  logic [2*RW-1:0]   rad_q;
  logic [RW-1:0]     root_q;
  logic [RW:0]       srem_q;

  logic [CNT_W:0]    div_sh;
  logic [CNT_W:0]    div_diff;
  logic              div_ge;
  logic [QW-1:0]     quot_next;
  logic [RW+2:0]     sq_sh;
  logic [RW+2:0]     sq_trial;
  logic [RW+2:0]     sq_diff;
  logic              sq_ge;

  // one quotient bit per cycle
  assign div_sh    = {rem_q, dvd_q[QW-1]};
  assign div_ge    = div_sh >= {1'b0, den_q};
  assign div_diff  = div_sh - {1'b0, den_q};
  assign quot_next = {dvd_q[QW-2:0], div_ge};

  // one root bit per cycle
  assign sq_sh    = {srem_q, rad_q[2*RW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      prlm_pkg::RT_IDLE: begin
        if (start_i) begin
          phase_d = prlm_pkg::RT_DIV;
        end
      end
      prlm_pkg::RT_DIV: begin
        if (step_q == '0) begin
          phase_d = prlm_pkg::RT_SQRT;
        end
      end
      prlm_pkg::RT_SQRT: begin
        if (step_q == '0) begin
          phase_d = prlm_pkg::RT_DONE;
        end
      end
      prlm_pkg::RT_DONE: begin
        phase_d = prlm_pkg::RT_IDLE;
      end
      default: phase_d = prlm_pkg::RT_IDLE;
    endcase
  end

  assign done_o = (phase_q == prlm_pkg::RT_DONE);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= prlm_pkg::RT_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == prlm_pkg::RT_IDLE && start_i) begin
        step_q <= StepW'(QW - 1);
      end else if (phase_q == prlm_pkg::RT_DIV && step_q == '0) begin
        step_q <= StepW'(RW - 1);
      end else if (step_q != '0) begin
        step_q <= step_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      prlm_pkg::RT_IDLE: begin
        if (start_i) begin
          rem_q <= CNT_W'(sum_i >> QW);
          dvd_q <= sum_i[QW-1:0];
          den_q <= cnt_i;
        end
      end
      prlm_pkg::RT_DIV: begin
        rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
        dvd_q <= quot_next;
        if (step_q == '0) begin
          rad_q  <= (2*RW)'(quot_next);
          root_q <= '0;
          srem_q <= '0;
        end
      end
      prlm_pkg::RT_SQRT: begin
        srem_q <= sq_ge ? sq_diff[RW:0] : sq_sh[RW:0];
        root_q <= {root_q[RW-2:0], sq_ge};
        rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/peak_rms_level_meter.sv */
// Multi-channel peak / RMS level meter. Samples and level reads enter on one
// channel; per-channel state (held peak, held block RMS, clip flag, running
// sum of squares and sample count) sits in a single-port-write RAM with
// registered read, and each sample or read-and-clear is a read-modify-write
// of its channel's entry. A sample that does not close a block, or a read,
// passes through the load and merge states before the next item can be
// taken; an ignored item (undefined kind, or a sample for an unmetered
// channel) is dropped without leaving the idle state. A read waits longer
// only while the result register still holds an untaken beat. A sample
// that closes a block adds the mean-of-squares and square-root unit:
// restoring division (one quotient bit per cycle), then square root (one
// bit per cycle), then a done state that hands back the root, before the
// next item can be taken. Entries come out of reset as zero through
// per-channel valid flags, so there is no clearing pass and items are
// taken right after reset. Configuration writes are taken in every cycle.
module peak_rms_level_meter #(
  parameter int unsigned NUM_CHANNELS = prlm_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_BLOCK    = prlm_pkg::MAX_BLOCK_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prlm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  prlm_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output prlm_pkg::out_item_t             out_item_o
);

  localparam int unsigned ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SumW = prlm_pkg::SQ_W - 1 + CntW;
  localparam int unsigned LW   = prlm_pkg::LEVEL_W;

  typedef struct packed {
    logic [LW-1:0]   peak;
    logic [LW-1:0]   rms;
    logic            clip;
    logic [SumW-1:0] sum;
    logic [CntW-1:0] cnt;
  } entry_t;

  localparam int unsigned EntW = $bits(entry_t);

  prlm_pkg::state_e state_q, state_d;

  logic [LW-1:0]                 thresh_q;
  logic [prlm_pkg::ACTIVE_W-1:0] active_q;

  prlm_pkg::in_item_t          item_q;
  logic [LW-1:0]               mag_q;
  logic                        blank_q;
  logic [ChW-1:0]              addr_q;
  logic [prlm_pkg::SQ_W-1:0]   sq_q;
  logic [NUM_CHANNELS-1:0]     vld_q;
  entry_t                      ent_q;

  logic                        out_valid_q;
  prlm_pkg::out_item_t         out_item_q;

  logic [prlm_pkg::SAMPLE_W-1:0] in_raw;
  logic [LW-1:0]                 in_mag;
  logic                          in_active;
  logic                          in_is_sample;
  logic                          in_is_read;
  logic                          in_go;
  logic                          in_acc;
  logic [2*prlm_pkg::SAMPLE_W-1:0] sq_full;

  entry_t          rd_ent;
  entry_t          upd_ent;
  entry_t          close_ent;
  entry_t          clr_ent;
  entry_t          fin_ent;
  logic            cnt_ok;
  logic [SumW-1:0] sum_new;
  logic [CntW-1:0] cnt_new;
  logic            item_sample;
  logic            item_clear;
  logic            slot_free;
  logic            needs_root;

  logic            ram_we;
  logic            ram_re;
  logic [EntW-1:0] ram_wdata;
  logic [EntW-1:0] ram_rdata;
  logic            root_start;
  logic            root_done;
  logic [LW-1:0]   root_val;
  logic            ent_load;
  logic            out_load;

  // input side
  assign in_raw       = in_item_i.sample;
  assign in_mag       = in_raw[prlm_pkg::SAMPLE_W-1] ? (~in_raw + LW'(1)) : in_raw;
  assign in_active    = ({1'b0, in_item_i.channel} < active_q) &&
                        (7'(in_item_i.channel) < 7'(NUM_CHANNELS));
  assign in_is_sample = (in_item_i.kind == prlm_pkg::KIND_SAMPLE);
  assign in_is_read   = (in_item_i.kind == prlm_pkg::KIND_READ) ||
                        (in_item_i.kind == prlm_pkg::KIND_READ_CLEAR);
  assign in_go        = (in_is_sample && in_active) || in_is_read;
  assign in_acc       = in_valid_i && in_ready_o;
  assign sq_full      = mag_q * mag_q;

  // entry update
  assign rd_ent  = (!blank_q && vld_q[addr_q]) ? entry_t'(ram_rdata) : '0;
  assign cnt_ok  = rd_ent.cnt < CntW'(MAX_BLOCK);
  assign sum_new = cnt_ok ? (rd_ent.sum + SumW'(sq_q)) : rd_ent.sum;
  assign cnt_new = cnt_ok ? (rd_ent.cnt + CntW'(1)) : rd_ent.cnt;

  always_comb begin
    upd_ent      = rd_ent;
    upd_ent.peak = (mag_q > rd_ent.peak) ? mag_q : rd_ent.peak;
    upd_ent.clip = rd_ent.clip | (mag_q >= thresh_q);
    upd_ent.sum  = sum_new;
    upd_ent.cnt  = cnt_new;

    close_ent     = upd_ent;
    close_ent.sum = '0;
    close_ent.cnt = '0;

    clr_ent      = rd_ent;
    clr_ent.peak = '0;
    clr_ent.rms  = '0;
    clr_ent.clip = 1'b0;

    fin_ent     = ent_q;
    fin_ent.rms = (root_val > ent_q.rms) ? root_val : ent_q.rms;
    fin_ent.sum = '0;
    fin_ent.cnt = '0;
  end

  assign item_sample = (item_q.kind == prlm_pkg::KIND_SAMPLE);
  assign item_clear  = (item_q.kind == prlm_pkg::KIND_READ_CLEAR);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign needs_root  = item_q.last_of_block && (cnt_new != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prlm_pkg::ST_IDLE: begin
        if (in_valid_i && in_go) begin
          state_d = prlm_pkg::ST_LOAD;
        end
      end
      prlm_pkg::ST_LOAD: begin
        state_d = prlm_pkg::ST_MERGE;
      end
      prlm_pkg::ST_MERGE: begin
        if (item_sample) begin
          state_d = needs_root ? prlm_pkg::ST_ROOT : prlm_pkg::ST_IDLE;
        end else if (slot_free) begin
          state_d = prlm_pkg::ST_IDLE;
        end
      end
      prlm_pkg::ST_ROOT: begin
        if (root_done) begin
          state_d = prlm_pkg::ST_IDLE;
        end
      end
      default: state_d = prlm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = upd_ent;
    root_start = 1'b0;
    ent_load   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      prlm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i && in_go;
      end
      prlm_pkg::ST_LOAD: begin
      end
      prlm_pkg::ST_MERGE: begin
        if (item_sample) begin
          if (needs_root) begin
            root_start = 1'b1;
            ent_load   = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = item_q.last_of_block ? close_ent : upd_ent;
          end
        end else if (slot_free) begin
          out_load  = 1'b1;
          ram_we    = item_clear && !blank_q;
          ram_wdata = clr_ent;
        end
      end
      prlm_pkg::ST_ROOT: begin
        ram_we    = root_done;
        ram_wdata = fin_ent;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prlm_pkg::ST_IDLE;
      thresh_q    <= prlm_pkg::THRESH_RESET;
      active_q    <= prlm_pkg::ACTIVE_RESET;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (ram_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          prlm_pkg::REG_CLIP_THRESHOLD:  thresh_q <= cfg_data_i[LW-1:0];
          prlm_pkg::REG_ACTIVE_CHANNELS: active_q <= cfg_data_i[prlm_pkg::ACTIVE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q  <= in_item_i;
      mag_q   <= in_mag;
      blank_q <= !in_active;
      addr_q  <= ChW'(in_item_i.channel);
    end
    if (state_q == prlm_pkg::ST_LOAD) begin
      sq_q <= sq_full[prlm_pkg::SQ_W-1:0];
    end
    if (ent_load) begin
      ent_q <= upd_ent;
    end
    if (out_load) begin
      out_item_q.peak_level <= rd_ent.peak;
      out_item_q.rms_level  <= rd_ent.rms;
      out_item_q.clipped    <= rd_ent.clip;
    end
  end

  prlm_ram #(
    .WIDTH (EntW),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ChW'(in_item_i.channel)),
    .rdata_o (ram_rdata)
  );

  prlm_mean_root #(
    .SUM_W (SumW),
    .CNT_W (CntW)
  ) u_mean_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .sum_i   (sum_new),
    .cnt_i   (cnt_new),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == prlm_pkg::ST_ROOT))
    else $error("root unit finished outside of block close");

  a_no_overwrite_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before its beat was taken");

  a_no_read_write_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("state ram read and written in the same cycle");

  a_root_start_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_start |-> (state_q == prlm_pkg::ST_MERGE && item_q.last_of_block && !blank_q))
    else $error("root unit started without a closing sample");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> vld_q[$past(addr_q)])
    else $error("written entry not marked valid");

endmodule
